// ----- rtl/drat_pkg.sv -----
// Shared constants, types and widths for the dual rolling average block.
package drat_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SAMPLE_W     = 12;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int TOTAL_W      = $clog2(WINDOW_DEPTH * ((1 << SAMPLE_W) - 1) + 1);
    localparam int STEP_W       = $clog2(TOTAL_W + 1);
    localparam int INDEX_W      = 1;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(1300);

    typedef enum logic [INDEX_W-1:0] {
        REG_BRAKE_THRESHOLD = 1'b0,
        REG_TANK_THRESHOLD  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] brake_sample;
        logic [SAMPLE_W-1:0] tank_sample;
    } sample_pair_t;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic         valid;
        sample_pair_t item;
    } queue_head_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] brake;
        logic [SAMPLE_W-1:0] tank;
    } thresholds_t;

endpackage

// ----- rtl/drat_channels.sv -----
// Valid/ready channel interfaces for sample pairs and average results.
interface drat_sample_if
    import drat_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] brake_sample;
    logic [SAMPLE_W-1:0] tank_sample;

    modport source (output valid, output brake_sample, output tank_sample, input ready);
    modport sink   (input valid, input brake_sample, input tank_sample, output ready);
endinterface

interface drat_average_if
    import drat_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] brake_average;
    logic [SAMPLE_W-1:0] tank_average;
    logic                level_error;

    modport source (output valid, output brake_average, output tank_average,
                    output level_error, input ready);
    modport sink   (input valid, input brake_average, input tank_average,
                    input level_error, output ready);
endinterface

// ----- rtl/drat_front.sv -----
// Front end: accept sample beats into a two-entry queue.
module drat_front
    import drat_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    drat_sample_if.sink         samples,
    input  logic                pop,
    output queue_head_t         head
);

    logic         [1:0] count_reg;
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    sample_pair_t       entry_reg [2];
    logic               push;

    assign samples.ready = (count_reg != 2'd2);
    assign push          = samples.valid && samples.ready;

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    // hold entries until popped
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].brake_sample <= samples.brake_sample;
            entry_reg[wr_ptr_reg].tank_sample  <= samples.tank_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- rtl/drat_back.sv -----
// Back end: window histories, running totals, shared serial divider, result register.
module drat_back
    import drat_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  queue_head_t         head,
    output logic                pop,
    input  thresholds_t         thresholds,
    drat_average_if.source      averages
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    state_t              state_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [COUNT_W-1:0]  filled_reg;
    logic [TOTAL_W-1:0]  brake_total_reg;
    logic [TOTAL_W-1:0]  tank_total_reg;
    logic [SAMPLE_W-1:0] brake_in_reg;
    logic [SAMPLE_W-1:0] tank_in_reg;
    logic [SAMPLE_W-1:0] brake_old_reg;
    logic [SAMPLE_W-1:0] tank_old_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [TOTAL_W-1:0]  quo_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                chan_reg;
    logic [SAMPLE_W-1:0] brake_avg_reg;
    logic [SAMPLE_W-1:0] tank_avg_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_brake_reg;
    logic [SAMPLE_W-1:0] out_tank_reg;
    logic                out_error_reg;

    logic [SAMPLE_W-1:0] brake_mem [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] tank_mem  [WINDOW_DEPTH];

    logic                window_full;
    logic [TOTAL_W-1:0]  brake_total_next;
    logic [TOTAL_W-1:0]  tank_total_next;
    logic [COUNT_W-1:0]  filled_next;
    logic [SLOT_W-1:0]   slot_next;
    logic [COUNT_W:0]    shifted;
    logic [COUNT_W:0]    diff;
    logic                fits;
    logic [COUNT_W-1:0]  rem_step;
    logic [TOTAL_W-1:0]  quo_step;
    logic                last_step;
    logic                out_free;

    assign window_full = (filled_reg == COUNT_W'(WINDOW_DEPTH));
    assign brake_total_next = brake_total_reg
                              - (window_full ? TOTAL_W'(brake_old_reg) : TOTAL_W'(0))
                              + TOTAL_W'(brake_in_reg);
    assign tank_total_next  = tank_total_reg
                              - (window_full ? TOTAL_W'(tank_old_reg) : TOTAL_W'(0))
                              + TOTAL_W'(tank_in_reg);
    assign filled_next = window_full ? filled_reg : filled_reg + COUNT_W'(1);
    assign slot_next   = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? SLOT_W'(0)
                                                                 : slot_reg + SLOT_W'(1);

    // one restoring division step per cycle
    assign shifted   = {rem_reg, quo_reg[TOTAL_W-1]};
    assign diff      = shifted - {1'b0, filled_reg};
    assign fits      = (shifted >= {1'b0, filled_reg});
    assign rem_step  = fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
    assign quo_step  = {quo_reg[TOTAL_W-2:0], fits};
    assign last_step = (step_reg == STEP_W'(TOTAL_W - 1));

    assign out_free = !out_valid_reg || averages.ready;
    assign pop      = (state_reg == ST_IDLE) && head.valid;

    assign averages.valid         = out_valid_reg;
    assign averages.brake_average = out_brake_reg;
    assign averages.tank_average  = out_tank_reg;
    assign averages.level_error   = out_error_reg;

    // history read on pop, write on update
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            brake_old_reg <= brake_mem[slot_reg];
            tank_old_reg  <= tank_mem[slot_reg];
        end
        if (state_reg == ST_UPDATE)
        begin
            brake_mem[slot_reg] <= brake_in_reg;
            tank_mem[slot_reg]  <= tank_in_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            slot_reg        <= '0;
            filled_reg      <= '0;
            brake_total_reg <= '0;
            tank_total_reg  <= '0;
            brake_in_reg    <= '0;
            tank_in_reg     <= '0;
            rem_reg         <= '0;
            quo_reg         <= '0;
            step_reg        <= '0;
            chan_reg        <= 1'b0;
            brake_avg_reg   <= '0;
            tank_avg_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_brake_reg   <= '0;
            out_tank_reg    <= '0;
            out_error_reg   <= 1'b0;
        end
        else
        begin
            // drop the result once taken, unless a new one is loaded this cycle
            if (out_valid_reg && averages.ready && (state_reg != ST_DELIVER))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (head.valid)
                    begin
                        brake_in_reg <= head.item.brake_sample;
                        tank_in_reg  <= head.item.tank_sample;
                        state_reg    <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    brake_total_reg <= brake_total_next;
                    tank_total_reg  <= tank_total_next;
                    filled_reg      <= filled_next;
                    slot_reg        <= slot_next;
                    rem_reg         <= '0;
                    quo_reg         <= brake_total_next;
                    step_reg        <= '0;
                    chan_reg        <= 1'b0;
                    state_reg       <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (last_step)
                    begin
                        if (!chan_reg)
                        begin
                            brake_avg_reg <= quo_step[SAMPLE_W-1:0];
                            rem_reg       <= '0;
                            quo_reg       <= tank_total_reg;
                            step_reg      <= '0;
                            chan_reg      <= 1'b1;
                        end
                        else
                        begin
                            tank_avg_reg <= quo_step[SAMPLE_W-1:0];
                            state_reg    <= ST_DELIVER;
                        end
                    end
                    else
                    begin
                        rem_reg  <= rem_step;
                        quo_reg  <= quo_step;
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_DELIVER:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_brake_reg <= brake_avg_reg;
                        out_tank_reg  <= tank_avg_reg;
                        out_error_reg <= (brake_avg_reg < thresholds.brake)
                                         || (tank_avg_reg < thresholds.tank);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/dual_rolling_average_threshold.sv -----
// Top level of the dual rolling average with low-level threshold flag.
//
// Use: each beat on the samples channel carries one brake and one tank
// pressure reading (12 bit each). Each beat gives exactly one beat on the
// averages channel: the truncated mean of each channel over the last
// WINDOW_DEPTH readings (fewer while the window fills) and level_error,
// set when either mean is below its threshold.
// Thresholds are written through wr_en / wr_index / wr_data; the user must
// write them only while idle, as the block does not enforce it. Index 0 is
// the brake threshold, index 1 the tank threshold, both reset to 1300.
// Sequence: after acceptance a beat reaches the queue head, where the history
// is read as it is popped, then the totals are updated, then a single
// restoring divider runs TOTAL_W steps per channel, and last the output
// register is loaded once it is free.
// The shared divider works on one beat at a time: the back end takes no new
// beat from the queue until the last result is loaded.
// Stalls: a result waits in the output register while the back end already
// starts the next beat; the two-entry queue keeps taking beats until full.
// Reset: totals, fill count, slot pointer and queue clear; history contents
// are don't-care and are never used before being written.
module dual_rolling_average_threshold
    import drat_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    drat_sample_if.sink         samples,
    drat_average_if.source      averages,
    input  logic                wr_en,
    input  logic [INDEX_W-1:0]  wr_index,
    input  logic [SAMPLE_W-1:0] wr_data
);

    thresholds_t thresholds_reg;
    queue_head_t head;
    logic        pop;

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresholds_reg.brake <= THRESHOLD_RESET;
            thresholds_reg.tank  <= THRESHOLD_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_BRAKE_THRESHOLD: thresholds_reg.brake <= wr_data;
                REG_TANK_THRESHOLD:  thresholds_reg.tank  <= wr_data;
                default:             thresholds_reg       <= thresholds_reg;
            endcase
        end
    end

    drat_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .pop     (pop),
        .head    (head)
    );

    drat_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .thresholds (thresholds_reg),
        .averages   (averages)
    );

endmodule
